[rtl/assert_macros.svh]
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/sso_pkg.sv]
// package: types, constants and state codes of the superstring order block
package sso_pkg;
    localparam int MaxStrings = 15;
    localparam int MaxLen = 64;
    localparam int SlotW = 4;
    localparam int LenW = 7;
    localparam int PosW = 6;
    localparam int CharAddrW = 10;
    localparam int MaskW = MaxStrings;
    localparam int DpAddrW = SlotW + MaskW;
    localparam int TotW = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_string;
        logic       end_of_set;
    } in_item_t;

    typedef struct packed {
        logic [3:0]      piece_index;
        logic [5:0]      skip_chars;
        logic [TotW-1:0] total_overlap;
        logic            last_piece;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_FIN_INIT,
        ST_CONT_START,
        ST_CONT_CMP,
        ST_CONT_WAIT,
        ST_CONT_EVAL,
        ST_COMPACT,
        ST_CMOVE,
        ST_CMOVE_WR,
        ST_SOLVE_CHK,
        ST_OV_START,
        ST_OV_CMP,
        ST_OV_WAIT,
        ST_OV_EVAL,
        ST_DP_INIT,
        ST_DP_READ,
        ST_DP_WAIT,
        ST_DP_ACC,
        ST_DP_WRITE,
        ST_RC_READ,
        ST_RC_WAIT,
        ST_RC_EMIT,
        ST_RC_HOLD,
        ST_CLEAR
    } state_t;
endpackage

[rtl/sso_char_ram.sv]
// character store: one write port, one registered read port
module sso_char_ram
    import sso_pkg::*;
(
    input  logic                 aclk,
    input  logic                 we,
    input  logic [CharAddrW-1:0] waddr,
    input  logic [7:0]           wdata,
    input  logic [CharAddrW-1:0] raddr,
    output logic [7:0]           rdata
);
    logic [7:0] mem [0:MaxStrings*MaxLen-1];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end
endmodule

[rtl/shortest_superstring_order.sv]
// top level: string loading, containment filter, overlap table, bitmask dp
// Shortest superstring order.
// s_ channel: one character per request (ch, end_of_string, end_of_set).
// m_ channel: one result per kept string, in superstring order, with the
// load index, the characters to skip, the total overlap and a last flag.
// Ordinary characters go into the load buffer. The end of a string runs a
// containment check in both directions against each kept string through
// the one read port of the character memory, comparing one character per
// pass through the start, compare, wait and evaluate states, followed by a
// compaction that copies each written slot one character at a time. The end
// of a set then builds the overlap table (for each ordered pair up to min
// length candidate shifts, compared through the matching states) and walks
// the dp over (k+1) * 2^k states: read, wait and accumulate per unvisited
// candidate, a read per visited one, then a final check and the write; the
// dp tables sit in one memory of 16 * 32768 entries with a registered read.
// Results leave one at a time via read, wait, emit and hold, held while
// m_ready is low; no new request is taken until the set is fully delivered.
// Reset (aresetn low, synchronous) empties the kept set and load buffer.
// The dp memory needs no clearing since every entry is written before read.
module shortest_superstring_order
    import sso_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
`include "assert_macros.svh"

    state_t state_reg, state_next;

    // load buffer (64 entries, read at one signal address -> small memory)
    logic [7:0] lbuf [0:MaxLen-1];
    logic [7:0] lbuf_q;
    logic [PosW-1:0] lbuf_raddr;
    logic [LenW-1:0] load_len_reg, load_len_next;
    logic [SlotW-1:0] load_count_reg, load_count_next;
    logic set_end_reg, set_end_next;

    // per slot info
    logic [LenW-1:0] slen_reg [0:MaxStrings-1];
    logic [SlotW-1:0] korig_reg [0:MaxStrings-1];
    logic [SlotW-1:0] kept_reg, kept_next;
    logic [MaxStrings-1:0] rm_reg, rm_next;
    logic dropped_reg, dropped_next;

    // overlap table memory, addressed by {slot a, slot b}
    logic [5:0] ovl_mem [0:(1<<(2*SlotW))-1];
    logic [5:0] ovl_q;
    logic [2*SlotW-1:0] ovl_raddr;

    // loop counters
    logic [SlotW-1:0] ja_reg, ja_next, jb_reg, jb_next, wr_reg, wr_next;
    logic [LenW-1:0] off_reg, off_next, pos_reg, pos_next;
    logic dir_reg, dir_next; // 0: new inside kept, 1: kept inside new
    logic placed_reg, placed_next;

    // char ram
    logic cr_we;
    logic [CharAddrW-1:0] cr_waddr, cr_raddr;
    logic [7:0] cr_wdata, cr_q;

    sso_char_ram u_chr (
        .aclk  (aclk),
        .we    (cr_we),
        .waddr (cr_waddr),
        .wdata (cr_wdata),
        .raddr (cr_raddr),
        .rdata (cr_q)
    );

    // dp memory
    logic [TotW+SlotW-1:0] dp_mem [0:(1<<DpAddrW)-1];
    logic [TotW+SlotW-1:0] dp_q, dp_wdata;
    logic [DpAddrW-1:0] dp_raddr, dp_waddr;
    logic dp_we;
    logic [MaskW-1:0] mask_reg, mask_next;
    logic [SlotW-1:0] r_reg, r_next, n_reg, n_next;
    logic [TotW:0] best_reg, best_next_v;
    logic [SlotW-1:0] pick_reg, pick_next;
    logic [TotW-1:0] total_reg, total_next;
    logic [SlotW-1:0] emit_reg, emit_next;
    out_item_t out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (dp_we) begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
        dp_q <= dp_mem[dp_raddr];
    end

    // load buffer write and read
    logic lb_we;
    always_ff @(posedge aclk) begin
        if (lb_we) begin
            lbuf[load_len_reg[PosW-1:0]] <= s_data.ch;
        end
        lbuf_q <= lbuf[lbuf_raddr];
    end

    // helper values
    logic [LenW-1:0] la, lb_len, minl, cand;
    logic [MaskW-1:0] full_mask;
    logic [LenW-1:0] lnew;
    always_comb begin
        lnew = load_len_reg;
        full_mask = MaskW'((1 << kept_reg) - 1);
        la = slen_reg[ja_reg];
        lb_len = slen_reg[jb_reg];
        minl = (la < lb_len) ? la : lb_len;
        cand = minl - off_reg; // current overlap candidate length n
    end

    // dp candidate sum and stored pick
    logic [TotW:0] acc_v;
    logic [SlotW-1:0] rc_pick;
    assign acc_v = {1'b0, dp_q[TotW+SlotW-1:SlotW]}
                 + (TotW+1)'((r_reg == '0) ? 6'd0 : ovl_q);
    assign rc_pick = dp_q[SlotW-1:0];

    // the string inside the containment check: dir 0 short = new, long = kept
    logic [LenW-1:0] short_len, long_len;
    always_comb begin
        if (!dir_reg) begin
            short_len = lnew;
            long_len = la;
        end else begin
            short_len = la;
            long_len = lnew;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (s_valid && s_ready &&
                         (s_data.end_of_string || s_data.end_of_set)) begin
                if (load_count_reg < SlotW'(MaxStrings)) state_next = ST_FIN_INIT;
                else if (s_data.end_of_set) state_next = ST_SOLVE_CHK;
            end
            ST_FIN_INIT: state_next = ST_CONT_START;
            ST_CONT_START: begin
                if (dir_reg && ja_reg >= kept_reg) state_next = ST_COMPACT;
                else if (!dir_reg && ja_reg >= kept_reg) state_next = ST_CONT_START;
                else if (short_len > long_len || off_reg + short_len > long_len)
                    state_next = ST_CONT_START;
                else if (pos_reg >= short_len) state_next = ST_CONT_START;
                else state_next = ST_CONT_CMP;
            end
            ST_CONT_CMP: state_next = ST_CONT_WAIT;
            ST_CONT_WAIT: state_next = ST_CONT_EVAL;
            ST_CONT_EVAL: state_next = ST_CONT_START;
            ST_COMPACT: begin
                if (dropped_reg) state_next = set_end_reg ? ST_SOLVE_CHK : ST_LOAD;
                else if (ja_reg >= kept_reg) begin
                    if (!placed_reg && wr_reg < SlotW'(MaxStrings)) state_next = ST_CMOVE;
                    else state_next = set_end_reg ? ST_SOLVE_CHK : ST_LOAD;
                end else if (rm_reg[ja_reg] && !placed_reg) state_next = ST_CMOVE;
                else if (!rm_reg[ja_reg] && wr_reg != ja_reg) state_next = ST_CMOVE;
                else state_next = ST_COMPACT;
            end
            ST_CMOVE: state_next = ST_CMOVE_WR;
            ST_CMOVE_WR: state_next =
                (pos_reg == LenW'(MaxLen - 1)) ? ST_COMPACT : ST_CMOVE;
            ST_SOLVE_CHK: state_next = (kept_reg == '0) ? ST_CLEAR : ST_OV_START;
            ST_OV_START: begin
                if (ja_reg >= kept_reg) state_next = ST_DP_INIT;
                else if (cand == '0 || pos_reg >= cand) state_next = ST_OV_START;
                else state_next = ST_OV_CMP;
            end
            ST_OV_CMP: state_next = ST_OV_WAIT;
            ST_OV_WAIT: state_next = ST_OV_EVAL;
            ST_OV_EVAL: state_next = ST_OV_START;
            ST_DP_INIT: state_next = (r_reg == kept_reg) ?
                ((mask_reg == '0) ? ST_RC_READ : ST_DP_READ) : ST_DP_INIT;
            ST_DP_READ: begin
                if (n_reg >= kept_reg) state_next = ST_DP_WRITE;
                else if (mask_reg[n_reg]) state_next = ST_DP_READ;
                else state_next = ST_DP_WAIT;
            end
            ST_DP_WAIT: state_next = ST_DP_ACC;
            ST_DP_ACC: state_next = ST_DP_READ;
            ST_DP_WRITE: begin
                if (r_reg == kept_reg && mask_reg == '0) state_next = ST_RC_READ;
                else state_next = ST_DP_READ;
            end
            ST_RC_READ: state_next = ST_RC_WAIT;
            ST_RC_WAIT: state_next = ST_RC_EMIT;
            ST_RC_EMIT: state_next = ST_RC_HOLD;
            ST_RC_HOLD: if (m_ready) begin
                state_next = out_reg.last_piece ? ST_CLEAR : ST_RC_READ;
            end
            ST_CLEAR: state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    logic ovl_we;
    logic [5:0] ovl_wdata;
    logic slot_we;
    logic [SlotW-1:0] slot_wa;
    logic [LenW-1:0] slot_wlen;
    logic [SlotW-1:0] slot_worig;
    always_comb begin
        load_len_next = load_len_reg;
        load_count_next = load_count_reg;
        set_end_next = set_end_reg;
        kept_next = kept_reg;
        rm_next = rm_reg;
        dropped_next = dropped_reg;
        ja_next = ja_reg;
        jb_next = jb_reg;
        wr_next = wr_reg;
        off_next = off_reg;
        pos_next = pos_reg;
        dir_next = dir_reg;
        placed_next = placed_reg;
        mask_next = mask_reg;
        r_next = r_reg;
        n_next = n_reg;
        best_next_v = best_reg;
        pick_next = pick_reg;
        total_next = total_reg;
        emit_next = emit_reg;
        out_next = out_reg;
        lb_we = 1'b0;
        lbuf_raddr = '0;
        cr_we = 1'b0;
        cr_waddr = '0;
        cr_wdata = lbuf_q;
        cr_raddr = '0;
        dp_we = 1'b0;
        dp_waddr = '0;
        dp_wdata = '0;
        dp_raddr = '0;
        ovl_we = 1'b0;
        ovl_wdata = '0;
        ovl_raddr = '0;
        slot_we = 1'b0;
        slot_wa = wr_reg;
        slot_wlen = lnew;
        slot_worig = load_count_reg;
        s_ready = (state_reg == ST_LOAD);
        m_valid = (state_reg == ST_RC_HOLD);
        case (state_reg)
            ST_LOAD: if (s_valid) begin
                if (load_len_reg < LenW'(MaxLen)) begin
                    lb_we = 1'b1;
                    load_len_next = load_len_reg + 1'b1;
                end
                set_end_next = s_data.end_of_set;
                if (s_data.end_of_string || s_data.end_of_set) begin
                    if (load_count_reg >= SlotW'(MaxStrings)) load_len_next = '0;
                end
            end
            ST_FIN_INIT: begin
                ja_next = '0;
                off_next = '0;
                pos_next = '0;
                dir_next = 1'b0;
                rm_next = '0;
                dropped_next = 1'b0;
                placed_next = 1'b0;
                wr_next = '0;
            end
            ST_CONT_START: begin
                if (ja_reg >= kept_reg) begin
                    if (!dir_reg) begin
                        dir_next = 1'b1;
                        ja_next = '0;
                    end else begin
                        ja_next = '0;
                    end
                    off_next = '0;
                    pos_next = '0;
                end else if (short_len > long_len || off_reg + short_len > long_len) begin
                    // no placement left: not contained
                    ja_next = ja_reg + 1'b1;
                    off_next = '0;
                    pos_next = '0;
                end else if (pos_reg >= short_len) begin
                    // full match found
                    if (!dir_reg) begin
                        dropped_next = 1'b1;
                        dir_next = 1'b1;
                        ja_next = kept_reg;
                    end else begin
                        rm_next[ja_reg] = 1'b1;
                        ja_next = ja_reg + 1'b1;
                    end
                    off_next = '0;
                    pos_next = '0;
                end
            end
            ST_CONT_CMP, ST_CONT_WAIT: begin
                // read short char at pos and long char at off+pos, held over the wait
                if (!dir_reg) begin
                    lbuf_raddr = pos_reg[PosW-1:0];
                    cr_raddr = CharAddrW'(ja_reg) * CharAddrW'(MaxLen)
                             + CharAddrW'(off_reg + pos_reg);
                end else begin
                    lbuf_raddr = PosW'(off_reg + pos_reg);
                    cr_raddr = CharAddrW'(ja_reg) * CharAddrW'(MaxLen)
                             + CharAddrW'(pos_reg);
                end
            end
            ST_CONT_EVAL: begin
                if (lbuf_q == cr_q) pos_next = pos_reg + 1'b1;
                else begin
                    pos_next = '0;
                    off_next = off_reg + 1'b1;
                end
            end
            ST_COMPACT: begin
                pos_next = '0;
                if (dropped_reg) begin
                    load_count_next = load_count_reg + 1'b1;
                    load_len_next = '0;
                end else if (ja_reg >= kept_reg) begin
                    if (placed_reg || wr_reg >= SlotW'(MaxStrings)) begin
                        kept_next = wr_reg;
                        load_count_next = load_count_reg + 1'b1;
                        load_len_next = '0;
                    end
                end else if (!(rm_reg[ja_reg] && !placed_reg) &&
                             !(!rm_reg[ja_reg] && wr_reg != ja_reg)) begin
                    if (!rm_reg[ja_reg]) wr_next = wr_reg + 1'b1;
                    ja_next = ja_reg + 1'b1;
                end
            end
            ST_CMOVE: begin
                // read source char: load buffer or slot ja
                lbuf_raddr = pos_reg[PosW-1:0];
                cr_raddr = CharAddrW'(ja_reg) * CharAddrW'(MaxLen) + CharAddrW'(pos_reg);
            end
            ST_CMOVE_WR: begin
                cr_we = 1'b1;
                cr_waddr = CharAddrW'(wr_reg) * CharAddrW'(MaxLen) + CharAddrW'(pos_reg);
                if (ja_reg >= kept_reg || rm_reg[ja_reg]) cr_wdata = lbuf_q;
                else cr_wdata = cr_q;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LenW'(MaxLen - 1)) begin
                    pos_next = '0;
                    slot_we = 1'b1;
                    if (ja_reg >= kept_reg || rm_reg[ja_reg]) begin
                        placed_next = 1'b1;
                    end else begin
                        slot_wlen = la;
                        slot_worig = korig_reg[ja_reg];
                    end
                    wr_next = wr_reg + 1'b1;
                    if (ja_reg < kept_reg) ja_next = ja_reg + 1'b1;
                end
            end
            ST_SOLVE_CHK: begin
                ja_next = '0;
                jb_next = '0;
                off_next = '0;
                pos_next = '0;
            end
            ST_OV_START: begin
                if (ja_reg < kept_reg) begin
                    if (cand == '0 || pos_reg >= cand) begin
                        ovl_we = 1'b1;
                        ovl_wdata = 6'(cand);
                        off_next = '0;
                        pos_next = '0;
                        if (jb_reg + 1'b1 >= kept_reg) begin
                            jb_next = '0;
                            ja_next = ja_reg + 1'b1;
                        end else jb_next = jb_reg + 1'b1;
                    end
                end else begin
                    mask_next = full_mask;
                    r_next = '0;
                end
            end
            ST_OV_CMP: begin
                // a[la - cand + pos] vs b[pos]; b is read in the following wait state
                cr_raddr = CharAddrW'(ja_reg) * CharAddrW'(MaxLen)
                         + CharAddrW'(la - cand + pos_reg);
            end
            ST_OV_WAIT: begin
                cr_raddr = CharAddrW'(jb_reg) * CharAddrW'(MaxLen) + CharAddrW'(pos_reg);
                best_next_v = {{(TotW-7){1'b0}}, cr_q};
            end
            ST_OV_EVAL: begin
                if (best_reg[7:0] == cr_q) pos_next = pos_reg + 1'b1;
                else begin
                    pos_next = '0;
                    off_next = off_reg + 1'b1;
                end
            end
            ST_DP_INIT: begin
                dp_we = 1'b1;
                dp_waddr = {r_reg, full_mask};
                dp_wdata = '0;
                r_next = r_reg + 1'b1;
                if (r_reg == kept_reg) begin
                    r_next = '0;
                    n_next = '0;
                    best_next_v = '1;
                    pick_next = '0;
                    if (mask_reg != '0) mask_next = mask_reg - 1'b1;
                end
            end
            ST_DP_READ, ST_DP_WAIT: begin
                // candidate entry and its overlap, held over the wait
                dp_raddr = {n_reg + 1'b1, mask_reg | MaskW'(1 << n_reg)};
                ovl_raddr = {r_reg - 1'b1, n_reg};
                if (n_reg < kept_reg && mask_reg[n_reg]) n_next = n_reg + 1'b1;
            end
            ST_DP_ACC: begin
                if (best_reg[TotW] || acc_v > best_reg) begin
                    best_next_v = acc_v;
                    pick_next = n_reg;
                end
                n_next = n_reg + 1'b1;
            end
            ST_DP_WRITE: begin
                dp_we = 1'b1;
                dp_waddr = {r_reg, mask_reg};
                dp_wdata = {best_reg[TotW-1:0], pick_reg};
                n_next = '0;
                best_next_v = '1;
                pick_next = '0;
                if (r_reg == kept_reg) begin
                    r_next = '0;
                    if (mask_reg == '0) begin
                        emit_next = '0;
                        mask_next = '0;
                        total_next = best_reg[TotW-1:0];
                    end else mask_next = mask_reg - 1'b1;
                end else r_next = r_reg + 1'b1;
                if (r_reg == '0 && mask_reg == '0) total_next = best_reg[TotW-1:0];
            end
            ST_RC_READ: dp_raddr = {r_reg, mask_reg};
            ST_RC_WAIT: begin
                // keep the entry for the emit cycle and fetch its overlap
                dp_raddr = {r_reg, mask_reg};
                ovl_raddr = {r_reg - 1'b1, rc_pick};
            end
            ST_RC_EMIT: begin
                if (r_reg == '0 && mask_reg == '0 && emit_reg == '0)
                    total_next = dp_q[TotW+SlotW-1:SlotW];
                out_next.piece_index = korig_reg[rc_pick];
                out_next.skip_chars = (r_reg == '0) ? 6'd0 : ovl_q;
                out_next.total_overlap = (r_reg == '0 && mask_reg == '0)
                    ? dp_q[TotW+SlotW-1:SlotW] : total_reg;
                out_next.last_piece = (emit_reg + 1'b1 == kept_reg);
                mask_next = mask_reg | MaskW'(1 << rc_pick);
                r_next = rc_pick + 1'b1;
                emit_next = emit_reg + 1'b1;
            end
            ST_RC_HOLD: ;
            ST_CLEAR: begin
                kept_next = '0;
                load_count_next = '0;
                load_len_next = '0;
                set_end_next = 1'b0;
                r_next = '0;
                mask_next = '0;
            end
            default: ;
        endcase
        m_data = out_reg;
    end

    // overlap table write and registered read
    always_ff @(posedge aclk) begin
        if (ovl_we) begin
            ovl_mem[{ja_reg, jb_reg}] <= ovl_wdata;
        end
        ovl_q <= ovl_mem[ovl_raddr];
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            load_len_reg <= '0;
            load_count_reg <= '0;
            kept_reg <= '0;
            set_end_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            load_len_reg <= load_len_next;
            load_count_reg <= load_count_next;
            kept_reg <= kept_next;
            set_end_reg <= set_end_next;
        end
    end

    always_ff @(posedge aclk) begin
        rm_reg <= rm_next;
        dropped_reg <= dropped_next;
        ja_reg <= ja_next;
        jb_reg <= jb_next;
        wr_reg <= wr_next;
        off_reg <= off_next;
        pos_reg <= pos_next;
        dir_reg <= dir_next;
        placed_reg <= placed_next;
        mask_reg <= mask_next;
        r_reg <= r_next;
        n_reg <= n_next;
        best_reg <= best_next_v;
        pick_reg <= pick_next;
        total_reg <= total_next;
        emit_reg <= emit_next;
        out_reg <= out_next;
        if (slot_we) begin
            slen_reg[slot_wa] <= slot_wlen;
            korig_reg[slot_wa] <= slot_worig;
        end
    end

    // checks
    `ASSERT_IMPL(a_kept_bound, aclk, aresetn, 1'b1, kept_reg <= SlotW'(MaxStrings))
    `ASSERT_IMPL(a_no_overlap_io, aclk, aresetn, m_valid, !s_ready)
    `ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
endmodule

[tb/tb_shortest_superstring_order.sv]
// testbench for the shortest superstring order block: self-checking, random stalls
`timescale 1ns / 1ps

module tb_shortest_superstring_order;
    import sso_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    shortest_superstring_order dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // request stimulus, with a flag that holds the request until all results are back
    in_item_t  char_q[$];
    bit        drain_q[$];
    out_item_t piece_q[$];

    int total_reqs;
    int n_accepted;
    int n_pieces;
    int n_sets;
    int n_errors;
    int phase;
    bit take;

    // predictor copy of the kept strings and the load buffer
    bit [7:0] kept_chars [MaxStrings][MaxLen];
    int       kept_len [MaxStrings];
    int       kept_org [MaxStrings];
    int       kept_cnt;
    bit [7:0] load_buf [MaxLen];
    int       load_len;
    int       load_cnt;
    int       ovl [MaxStrings+1][MaxStrings+1];
    int       dp_tot [MaxStrings+1][1<<MaxStrings];
    int       dp_nxt [MaxStrings+1][1<<MaxStrings];

    always #10 aclk = ~aclk;

    // true if string s occurs anywhere inside string b
    function automatic bit occurs_in(bit [7:0] b [MaxLen], int bl, bit [7:0] s [MaxLen], int sl);
        bit hit;
        if (sl > bl) return 0;
        for (int off = 0; off + sl <= bl; off++) begin
            hit = 1;
            for (int i = 0; i < sl; i++)
                if (b[off+i] != s[i]) hit = 0;
            if (hit) return 1;
        end
        return 0;
    endfunction

    // longest suffix of a that is a prefix of b
    function automatic int overlap_len(int a, int b);
        int  n;
        bit  hit;
        n = kept_len[a] < kept_len[b] ? kept_len[a] : kept_len[b];
        while (n > 0) begin
            hit = 1;
            for (int i = 0; i < n; i++)
                if (kept_chars[a][kept_len[a]-n+i] != kept_chars[b][i]) hit = 0;
            if (hit) return n;
            n--;
        end
        return 0;
    endfunction

    // containment filter applied when a string completes
    function automatic void close_string();
        int w;
        bit placed;
        w = 0;
        placed = 0;
        for (int j = 0; j < kept_cnt; j++)
            if (occurs_in(kept_chars[j], kept_len[j], load_buf, load_len)) return;
        for (int j = 0; j < kept_cnt; j++) begin
            if (occurs_in(load_buf, load_len, kept_chars[j], kept_len[j])) begin
                if (!placed) begin
                    kept_chars[w] = load_buf;
                    kept_len[w] = load_len;
                    kept_org[w] = load_cnt;
                    placed = 1;
                    w++;
                end
            end else begin
                if (w != j) begin
                    kept_chars[w] = kept_chars[j];
                    kept_len[w] = kept_len[j];
                    kept_org[w] = kept_org[j];
                end
                w++;
            end
        end
        if (!placed && w < MaxStrings) begin
            kept_chars[w] = load_buf;
            kept_len[w] = load_len;
            kept_org[w] = load_cnt;
            w++;
        end
        kept_cnt = w;
    endfunction

    // overlap table, bitmask dp with lowest slot on ties, then the piece order
    function automatic void order_pieces();
        int k, full, best, pick, v, r, n, mask, tot;
        out_item_t p;
        k = kept_cnt;
        for (int a = 0; a < k; a++)
            for (int b = 0; b < k; b++)
                ovl[a+1][b+1] = overlap_len(a, b);
        for (int b = 0; b <= k; b++) ovl[0][b] = 0;
        full = (1 << k) - 1;
        for (int q = 0; q <= k; q++) begin
            dp_tot[q][full] = 0;
            dp_nxt[q][full] = 0;
        end
        for (int m = full - 1; m >= 0; m--) begin
            for (int q = 0; q <= k; q++) begin
                best = -1;
                pick = 0;
                for (int c = 0; c < k; c++) begin
                    if (!m[c]) begin
                        v = dp_tot[c+1][m | (1 << c)] + ovl[q][c+1];
                        if (v > best) begin
                            best = v;
                            pick = c;
                        end
                    end
                end
                dp_tot[q][m] = best;
                dp_nxt[q][m] = pick;
            end
        end
        tot = dp_tot[0][0];
        r = 0;
        mask = 0;
        for (int i = 0; i < k; i++) begin
            n = dp_nxt[r][mask] % k;
            p.piece_index = 4'(kept_org[n]);
            p.skip_chars = 6'(ovl[r][n+1]);
            p.total_overlap = 10'(tot);
            p.last_piece = (i + 1 == k);
            piece_q.push_back(p);
            mask |= 1 << n;
            r = n + 1;
        end
    endfunction

    // one accepted character request
    function automatic void predict_char(in_item_t it);
        if (load_len < MaxLen) begin
            load_buf[load_len] = it.ch;
            load_len++;
        end
        if (it.end_of_string || it.end_of_set) begin
            if (load_cnt < MaxStrings) begin
                close_string();
                load_cnt++;
            end
            load_len = 0;
        end
        if (it.end_of_set) begin
            if (kept_cnt > 0) order_pieces();
            n_sets++;
            kept_cnt = 0;
            load_cnt = 0;
            load_len = 0;
        end
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch on piece %0d: %s got %0d expected %0d", n_pieces, what, got, want);
        n_errors++;
    endtask

    // idle percentages per phase
    function automatic int send_idle();
        return phase == 0 ? 23 : (phase == 1 ? 55 : 0);
    endfunction
    function automatic int recv_idle();
        return phase == 0 ? 55 : (phase == 1 ? 23 : 0);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                predict_char(s_data);
                n_accepted++;
                phase = (n_accepted * 3) / (total_reqs + 1);
            end
            if (!s_valid || take) begin
                if (char_q.size() > 0 && !(drain_q[0] && piece_q.size() != 0)
                    && $urandom_range(99) >= send_idle()) begin
                    s_valid <= 1'b1;
                    s_data  <= char_q.pop_front();
                    void'(drain_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (piece_q.size() == 0) begin
                    $display("unexpected piece %0d", n_pieces);
                    n_errors++;
                end else begin
                    if (m_data.piece_index != piece_q[0].piece_index)
                        report("piece_index", m_data.piece_index, piece_q[0].piece_index);
                    if (m_data.skip_chars != piece_q[0].skip_chars)
                        report("skip_chars", m_data.skip_chars, piece_q[0].skip_chars);
                    if (m_data.total_overlap != piece_q[0].total_overlap)
                        report("total_overlap", m_data.total_overlap,
                               piece_q[0].total_overlap);
                    if (m_data.last_piece != piece_q[0].last_piece)
                        report("last_piece", m_data.last_piece, piece_q[0].last_piece);
                    void'(piece_q.pop_front());
                end
                n_pieces++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle());
        end
    end

    // queue one string; last closes the set
    task automatic add_string(bit [7:0] s [$], bit last, bit drain);
        in_item_t it;
        for (int i = 0; i < s.size(); i++) begin
            it.ch = s[i];
            it.end_of_string = (i == s.size() - 1) && (!last || $urandom_range(1));
            it.end_of_set = last && (i == s.size() - 1);
            char_q.push_back(it);
            drain_q.push_back(drain && i == 0);
        end
    endtask

    // random string over a small alphabet, sometimes full bytes
    function automatic void rand_string(output bit [7:0] s [$], input int len, input bit wide);
        s = {};
        for (int i = 0; i < len; i++)
            s.push_back(wide ? 8'($urandom) : 8'(8'h61 + $urandom_range(2)));
    endfunction

    initial begin
        bit [7:0] s [$];
        int nstr;
        aclk = 0;
        aresetn = 0;
        kept_cnt = 0;
        load_len = 0;
        load_cnt = 0;

        // single character set, top byte; end of set always, end of string at random
        add_string('{8'hff}, 1, 0);
        // extremes of the character and a chain of overlaps
        add_string('{8'h00, 8'hff, 8'h00}, 0, 0);
        add_string('{8'hff, 8'h00, 8'hff}, 1, 0);
        // equal, contained and containing strings
        add_string('{8'h78, 8'h79, 8'h7a}, 0, 1);
        add_string('{8'h79}, 0, 0);
        add_string('{8'h78, 8'h79, 8'h7a}, 0, 0);
        add_string('{8'h77, 8'h78, 8'h79, 8'h7a}, 0, 0);
        add_string('{8'h7a, 8'h77}, 1, 0);
        // more strings than slots in one set
        for (int i = 0; i < 16; i++) add_string('{8'h55 + 8'(i % 2)}, 0, 0);
        add_string('{8'h57}, 1, 0);
        // long string cut to the buffer size
        rand_string(s, 70, 1);
        add_string(s, 0, 0);
        add_string('{8'h01, 8'h02}, 1, 0);
        // one wider set of distinct strings
        for (int i = 0; i < 9; i++) begin
            rand_string(s, 6, 1);
            add_string(s, i == 8, i == 0);
        end

        // random sets with random content
        while (char_q.size() < 200) begin
            nstr = $urandom_range(1, 6);
            for (int i = 0; i < nstr; i++) begin
                rand_string(s, $urandom_range(1, 6), $urandom_range(9) == 0);
                add_string(s, i == nstr - 1, i == 0 && $urandom_range(7) == 0);
            end
        end
        total_reqs = char_q.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1;

        wait (char_q.size() == 0 && !s_valid);
        wait (piece_q.size() == 0);
        repeat (200) @(posedge aclk);
        $display("covered %0d requests in %0d sets, %0d pieces checked",
                 n_accepted, n_sets, n_pieces);
        $display("stalls on both sides, containment, overflow and long strings exercised");
        if (n_errors == 0 && piece_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end
endmodule
